>>> rtl/cbm_pkg.sv
package cbm_pkg;

    // bus map
    localparam logic [15:0] ROM_BANKED_BASE = 16'h4000;
    localparam logic [15:0] VIDEO_BASE      = 16'h8000;
    localparam logic [15:0] RAM_BASE        = 16'hA000;
    localparam logic [15:0] OUTSIDE_BASE    = 16'hC000;
    localparam logic [15:0] REG_ROM_LO      = 16'h2000;
    localparam logic [15:0] REG_ROM_HI      = 16'h4000;
    localparam logic [15:0] REG_MODE        = 16'h6000;

    // cartridge RAM geometry
    localparam int RAM_BANKS      = 4;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_2KB_BYTES  = 2048;
    localparam int BANK_W         = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
    localparam int OFF_W          = $clog2(RAM_BANK_BYTES);
    localparam int RAM_AW         = $clog2(RAM_BANKS * RAM_BANK_BYTES);
    localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;

    localparam int ROM_AW      = 21;
    localparam int ROM_BANK_W  = 7;
    localparam int ROM_PAGE_W  = 14;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_VIDEO     = 3'd1;
    localparam logic [2:0] ST_NO_RAM    = 3'd2;
    localparam logic [2:0] ST_BEYOND_2K = 3'd3;
    localparam logic [2:0] ST_OUTSIDE   = 3'd4;

    // configuration register indexes
    localparam logic CFG_HAS_RAM    = 1'b0;
    localparam logic CFG_RAM_IS_2KB = 1'b1;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        wdata;
    } ram_req_t;

    typedef struct packed {
        logic [ROM_AW-1:0] rom_address;
        logic              from_rom;
        logic [2:0]        status;
        logic              ram_en;
        logic              ram_rd;   // read_data comes from the RAM port
    } result_t;

endpackage

>>> rtl/cbm_ram.sv
module cbm_ram #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cbm_ctrl.sv
module cbm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic               func,
    input  logic [15:0]        address,
    input  logic [7:0]         write_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic               cfg_data,
    output cbm_pkg::ram_req_t  req,
    output cbm_pkg::result_t   res
);
    import cbm_pkg::*;

    logic                  has_ram_reg;
    logic                  ram_is_2kb_reg;
    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [BANK_W-1:0]     ram_bank_reg, ram_bank_next;
    logic                  banking_mode_reg, banking_mode_next;
    logic                  ram_enable_reg, ram_enable_next;

    logic [OFF_W-1:0]      off;
    logic [4:0]            lo_bits;

    assign off     = address[OFF_W-1:0];
    assign lo_bits = (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];

    always_comb
    begin
        rom_bank_next     = rom_bank_reg;
        ram_bank_next     = ram_bank_reg;
        banking_mode_next = banking_mode_reg;
        ram_enable_next   = ram_enable_reg;
        req               = '0;
        req.wdata         = write_data;
        req.addr          = {ram_bank_reg, off};
        res               = '0;

        priority if (address < VIDEO_BASE)
        begin
            if (!func)
            begin
                res.from_rom = 1'b1;
                if (address < ROM_BANKED_BASE)
                    res.rom_address = {{(ROM_AW-16){1'b0}}, address};
                else
                    res.rom_address = {rom_bank_reg, address[ROM_PAGE_W-1:0]};
            end
            else if (address < REG_ROM_LO)
            begin
                ram_enable_next = (write_data[3:0] == 4'hA);
            end
            else if (address < REG_ROM_HI)
            begin
                rom_bank_next = {rom_bank_reg[6:5], lo_bits};
            end
            else if (address < REG_MODE)
            begin
                if (banking_mode_reg)
                    ram_bank_next = write_data[BANK_W-1:0];
                else
                    rom_bank_next = {write_data[1:0], rom_bank_reg[4:0]};
            end
            else
            begin
                banking_mode_next = (write_data == 8'h01);
            end
        end
        else if (address < RAM_BASE)
        begin
            res.status = ST_VIDEO;
        end
        else if (address < OUTSIDE_BASE)
        begin
            if (!has_ram_reg)
                res.status = ST_NO_RAM;
            else if ((ram_is_2kb_reg && ({3'b0, address[12:0]} >= 16'(RAM_2KB_BYTES)))
                     || ({3'b0, address[12:0]} >= 16'(RAM_BANK_BYTES)))
                res.status = ST_BEYOND_2K;
            else
            begin
                req.we     = take & func;
                req.re     = take & ~func;
                res.ram_rd = ~func;
            end
        end
        else
        begin
            res.status = ST_OUTSIDE;
        end

        res.ram_en = ram_enable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg     <= ROM_BANK_W'(1);
            ram_bank_reg     <= '0;
            banking_mode_reg <= 1'b0;
            ram_enable_reg   <= 1'b0;
        end
        else if (take)
        begin
            rom_bank_reg     <= rom_bank_next;
            ram_bank_reg     <= ram_bank_next;
            banking_mode_reg <= banking_mode_next;
            ram_enable_reg   <= ram_enable_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_ram_reg    <= 1'b0;
            ram_is_2kb_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HAS_RAM:    has_ram_reg    <= cfg_data;
                CFG_RAM_IS_2KB: ram_is_2kb_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

endmodule

>>> rtl/cartridge_bank_mapper_unit.sv
// Channel      Dir  Handshake               Payload
// s_axis       in   s_axis_tvalid/tready    tdata: address, write_data; tuser: func
// m_axis       out  m_axis_tvalid/tready    tdata: read_data, rom_address, status,
//                                           ram_enabled_flag; tuser: from_rom
// cfg          in   cfg_we (no stall)       cfg_index, cfg_data
//
// Every transaction passes through one output register: decode and mapper
// register update at the accept edge, RAM port read/write on that same
// edge, result visible from the output register in the following cycle.
// One transaction per cycle is sustained while m_axis_tready stays high; the
// single output register gates s_axis_tready, and the RAM read data holds
// with it during a stall. Reset clears the mapper registers and config, not
// the cartridge RAM.
module cartridge_bank_mapper_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
    input  logic        s_axis_tuser,   // [0] func (1 = write)

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] read_data, [28:8] rom_address,
                                        // [31:29] status, [32] ram_enabled_flag, rest 0
    output logic        m_axis_tuser,   // [0] from_rom

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);
    import cbm_pkg::*;

    logic       take;
    ram_req_t   req;
    result_t    res;
    result_t    res_reg;
    logic       out_valid_reg;
    logic [7:0] ram_q;
    logic [7:0] read_data;

    // output register frees up when empty or being drained
    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign take          = s_axis_tvalid & s_axis_tready;

    cbm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .func       (s_axis_tuser),
        .address    (s_axis_tdata[15:0]),
        .write_data (s_axis_tdata[23:16]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .res        (res)
    );

    // cartridge RAM: a write lands at the accept edge, so a read right behind
    // it to the same byte already sees the new value
    cbm_ram #(
        .ADDR_W (RAM_AW),
        .DATA_W (8)
    ) u_ram (
        .clk   (clk),
        .we    (req.we),
        .re    (req.re),
        .addr  (req.addr),
        .wdata (req.wdata),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res;
        end
    end

    assign read_data     = res_reg.ram_rd ? ram_q : 8'h00;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.from_rom;
    assign m_axis_tdata  = {7'b0, res_reg.ram_en, res_reg.status,
                            res_reg.rom_address, read_data};

endmodule
